// ===== hdl/particle_table_euler_update_macros.svh =====
// Assertion macros used by the checker file of the particle table.
`ifndef PARTICLE_TABLE_EULER_UPDATE_MACROS_SVH
`define PARTICLE_TABLE_EULER_UPDATE_MACROS_SVH
// Asserts that an antecedent implies a consequence on the next clock edge.
`define PTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Asserts that an antecedent implies a consequence on the same clock edge.
`define PTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

// ===== hdl/pteu_pkg.sv =====
// Package with the types and constants of the particle table.
package pteu_pkg;
  localparam int unsigned LifeW = 17;
  localparam logic [LifeW-1:0] LifeOne = 17'h10000;
  localparam logic [0:0] ModeAdd = 1'b0;
  localparam logic [0:0] ModeTick = 1'b1;
  localparam logic [0:0] CfgGravity = 1'b0;
  localparam logic [0:0] CfgDecay = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic        vertex_valid;
    logic        last_vertex;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD_SCAN, ST_ADD_WR, ST_T_DEC, ST_T_RD, ST_T_WAIT,
    ST_T_LIFE, ST_T_VY, ST_T_PX, ST_T_PY, ST_T_EMIT, ST_T_NEXT, ST_T_END
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clr_idx;
    logic inc_idx;
    logic add_write;
    logic calc_dec;
    logic rd_slot;
    logic do_life;
    logic do_vy;
    logic do_px;
    logic do_py;
    logic emit;
    logic emit_empty;
  } ctrl_t;

  typedef struct packed {
    logic is_tick;
    logic idx_last;
    logic slot_act;
    logic slot_dies;
    logic have_pend;
  } stat_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -34'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// ===== hdl/pteu_ctrl.sv =====
// Controller state machine that sequences adds and ticks over the slots.
module pteu_ctrl import pteu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  stat_t  st,
  output logic   busy,
  output ctrl_t  cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_ADD_SCAN;
      ST_ADD_SCAN: begin
        if (st.is_tick) state_nxt = ST_T_DEC;
        else if (!st.slot_act) state_nxt = ST_ADD_WR;
        else if (st.idx_last) state_nxt = ST_IDLE;
      end
      ST_ADD_WR:   state_nxt = ST_IDLE;
      ST_T_DEC:    state_nxt = ST_T_RD;
      ST_T_RD:     state_nxt = st.slot_act ? ST_T_WAIT : ST_T_NEXT;
      ST_T_WAIT:   state_nxt = ST_T_LIFE;
      ST_T_LIFE:   state_nxt = st.slot_dies ? ST_T_NEXT : ST_T_VY;
      ST_T_VY:     state_nxt = ST_T_PX;
      ST_T_PX:     state_nxt = ST_T_PY;
      ST_T_PY:     state_nxt = ST_T_EMIT;
      ST_T_EMIT:   state_nxt = ST_T_NEXT;
      ST_T_NEXT:   state_nxt = st.idx_last ? ST_T_END : ST_T_RD;
      ST_T_END:    state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:     begin
        cmd.load_item = start;
        cmd.clr_idx = 1'b1;
      end
      ST_ADD_SCAN: begin
        if (st.is_tick) cmd.clr_idx = 1'b1;
        else if (st.slot_act) cmd.inc_idx = 1'b1;
      end
      ST_ADD_WR:   cmd.add_write = 1'b1;
      ST_T_DEC:    cmd.calc_dec = 1'b1;
      ST_T_RD:     cmd.rd_slot = 1'b1;
      ST_T_WAIT:   cmd.rd_slot = 1'b1;
      ST_T_LIFE:   cmd.do_life = 1'b1;
      ST_T_VY:     cmd.do_vy = 1'b1;
      ST_T_PX:     cmd.do_px = 1'b1;
      ST_T_PY:     cmd.do_py = 1'b1;
      ST_T_EMIT:   cmd.emit = 1'b1;
      ST_T_NEXT:   cmd.inc_idx = 1'b1;
      ST_T_END:    cmd.emit_empty = 1'b1;
      default:     cmd = '0;
    endcase
  end
endmodule

// ===== hdl/pteu_dp.sv =====
// Datapath with the slot memories, valid bits, multiplier and result register.
module pteu_dp import pteu_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  logic [31:0] gravity,
  input  logic [23:0] decay_rate,
  input  ctrl_t       cmd,
  output stat_t       st,
  output logic        out_strobe,
  output out_item_t   out_item
);
  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [NUM_SLOTS-1:0] act_r;
  logic [LifeW-1:0] life_r [NUM_SLOTS];
  logic [31:0] mem_px [NUM_SLOTS];
  logic [31:0] mem_py [NUM_SLOTS];
  logic [31:0] mem_vx [NUM_SLOTS];
  logic [31:0] mem_vy [NUM_SLOTS];
  logic [23:0] mem_col [NUM_SLOTS];

  in_item_t item_r;
  logic [IdxW-1:0] idx_r;
  logic [23:0] dec_r;
  logic [31:0] px_r, py_r, vx_r, vy_r;
  logic [23:0] col_r;
  logic [LifeW-1:0] life_w_r;
  logic [LifeW-1:0] nlife_r;
  logic pend_r;
  logic strobe_r;
  out_item_t res_r;

  logic signed [32:0] m_a;
  logic signed [48:0] m_p;
  logic signed [32:0] m_sh;
  logic signed [33:0] sum;
  logic [39:0] dec_full;
  logic [LifeW+7:0] alpha_full;
  out_item_t vtx;
  out_item_t tail;

  assign st.is_tick = item_r.mode == ModeTick;
  assign st.idx_last = (32'(idx_r) == NUM_SLOTS - 1);
  assign st.slot_act = act_r[idx_r];
  assign st.slot_dies = {7'd0, life_w_r} <= dec_r;
  assign st.have_pend = pend_r;

  assign dec_full = {16'd0, decay_rate} * {24'd0, item_r.time_step};

  always_comb begin
    m_a = {gravity[31], gravity};
    if (cmd.do_px) m_a = {vx_r[31], vx_r};
    else if (cmd.do_py) m_a = {vy_r[31], vy_r};
    m_p = m_a * $signed({1'b0, item_r.time_step});
    m_sh = m_p[48:16];
    if (cmd.do_vy) sum = {vy_r[31], vy_r[31], vy_r} - {m_sh[32], m_sh};
    else if (cmd.do_px) sum = {px_r[31], px_r[31], px_r} + {m_sh[32], m_sh};
    else sum = {py_r[31], py_r[31], py_r} + {m_sh[32], m_sh};
  end

  assign alpha_full = {8'd0, life_w_r} * 25'd255;

  always_comb begin
    vtx = '0;
    vtx.out_x = px_r;
    vtx.out_y = py_r;
    vtx.out_red = col_r[23:16];
    vtx.out_green = col_r[15:8];
    vtx.out_blue = col_r[7:0];
    vtx.out_alpha = alpha_full[23:16];
    vtx.vertex_valid = 1'b1;
  end

  always_comb begin
    tail = '0;
    if (pend_r) tail = res_r;
    tail.last_vertex = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_item;
    if (cmd.calc_dec) dec_r <= dec_full[39:16];
    if (cmd.add_write) begin
      mem_px[idx_r] <= item_r.pos_x;
      mem_py[idx_r] <= item_r.pos_y;
      mem_vx[idx_r] <= item_r.vel_x;
      mem_vy[idx_r] <= item_r.vel_y;
      mem_col[idx_r] <= {item_r.red, item_r.green, item_r.blue};
      life_r[idx_r] <= LifeOne;
    end
    if (cmd.rd_slot) begin
      px_r <= mem_px[idx_r];
      py_r <= mem_py[idx_r];
      vx_r <= mem_vx[idx_r];
      vy_r <= mem_vy[idx_r];
      col_r <= mem_col[idx_r];
      life_w_r <= life_r[idx_r];
    end
    if (cmd.do_life) begin
      nlife_r <= life_w_r - dec_r[LifeW-1:0];
      life_r[idx_r] <= st.slot_dies ? '0 : life_w_r - dec_r[LifeW-1:0];
    end
    if (cmd.do_vy) begin
      vy_r <= sat32(sum);
      mem_vy[idx_r] <= sat32(sum);
      life_w_r <= nlife_r;
    end
    if (cmd.do_px) begin
      px_r <= sat32(sum);
      mem_px[idx_r] <= sat32(sum);
    end
    if (cmd.do_py) begin
      py_r <= sat32(sum);
      mem_py[idx_r] <= sat32(sum);
    end
    if (cmd.emit) res_r <= vtx;
    else if (cmd.emit_empty) res_r <= '0;
  end

  // A held vertex is released when the next one is emitted, or with last_vertex once the tick's end is known.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      idx_r <= '0;
      pend_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (cmd.clr_idx) idx_r <= '0;
      else if (cmd.inc_idx && !st.idx_last) idx_r <= idx_r + 1'b1;
      if (cmd.add_write) act_r[idx_r] <= 1'b1;
      if (cmd.do_life && st.slot_dies) act_r[idx_r] <= 1'b0;
      if (cmd.emit) begin
        strobe_r <= pend_r;
        pend_r <= 1'b1;
      end
      if (cmd.emit_empty) begin
        strobe_r <= 1'b1;
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_item <= res_r;
    else if (cmd.emit_empty) out_item <= tail;
  end

  assign out_strobe = strobe_r;
endmodule

// ===== hdl/particle_table_euler_update.sv =====
// Top level of the particle table with Euler integration.
// Channel  Direction  Handshake             Payload
// in       input      start and not busy    in_item (in_item_t)
// out      output     out_strobe, one cycle out_item (out_item_t)
// cfg      input      cfg_valid, cfg_ready  cfg_index, cfg_data
// An add stays busy while it scans for a free slot.
// A tick is busy while it visits every slot; surviving slots are also integrated and emitted.
// Each vertex is held until the next one or the tick's end, so the last can carry last_vertex.
// Reset is synchronous and clears all slots; results cannot be stalled.
module particle_table_euler_update import pteu_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] gravity_r;
  logic [23:0] decay_r;
  ctrl_t cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= '0;
      decay_r <= 24'h010000;
    end else if (cfg_valid) begin
      if (cfg_index == CfgGravity) gravity_r <= cfg_data;
      else if (cfg_index == CfgDecay) decay_r <= cfg_data[23:0];
    end
  end

  pteu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .st(st), .busy(busy), .cmd(cmd)
  );

  pteu_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .gravity(gravity_r),
    .decay_rate(decay_r), .cmd(cmd), .st(st), .out_strobe(out_strobe),
    .out_item(out_item)
  );
endmodule

// ===== hdl/pteu_checker.sv =====
// Port checker for the particle table, bound to the top level.
`include "particle_table_euler_update_macros.svh"
module pteu_checker import pteu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);
  `PTE_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy did not rise")
  `PTE_ASSERT_SAME(a_strobe_busy, clk, rst_n, out_strobe && !out_item.last_vertex, busy,
    "vertex outside a transaction")
  `PTE_ASSERT_SAME(a_empty_last, clk, rst_n, out_strobe && !out_item.vertex_valid,
    out_item.last_vertex, "empty result not last")
endmodule

bind particle_table_euler_update pteu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_item(out_item)
);
